// ===== hdl/utf8_code_point_decoder_defines.svh =====
// assertion macros used by the checker file
`ifndef UTF8_CODE_POINT_DECODER_DEFINES_SVH
`define UTF8_CODE_POINT_DECODER_DEFINES_SVH

// property checked only while out of reset
`define U8D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define U8D_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/u8dec_pkg.sv =====
package u8dec_pkg;

    localparam int BYTE_W       = 8;
    localparam int CODE_POINT_W = 31;
    localparam int SEQ_LEN_W    = 3;
    localparam int PAYLOAD_W    = 6;

    localparam logic [SEQ_LEN_W-1:0] LEN_INVALID = 3'd0;
    localparam logic [SEQ_LEN_W-1:0] LEN_ONE     = 3'd1;

    localparam logic [1:0] CONT_TAG = 2'b10;

    // sequence length announced by a lead byte, LEN_INVALID for a bad lead
    function automatic logic [SEQ_LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [SEQ_LEN_W-1:0] len;
        begin
            case (b) inside
                [8'h00:8'h7F]: len = 3'd1;
                [8'h80:8'hBF]: len = LEN_INVALID;
                [8'hC0:8'hDF]: len = 3'd2;
                [8'hE0:8'hEF]: len = 3'd3;
                [8'hF0:8'hF7]: len = 3'd4;
                [8'hF8:8'hFB]: len = 3'd5;
                [8'hFC:8'hFD]: len = 3'd6;
                default:       len = LEN_INVALID;
            endcase
            return len;
        end
    endfunction

    // payload bits a lead byte keeps
    function automatic logic [BYTE_W-1:0] lead_payload(input logic [BYTE_W-1:0] b,
                                                       input logic [SEQ_LEN_W-1:0] len);
        logic [3:0] sh;
        begin
            sh = {1'b0, len} + 4'd1;
            return b & (8'hFF >> sh);
        end
    endfunction

endpackage

// ===== hdl/u8dec_byte_if.sv =====
interface u8dec_byte_if;
    import u8dec_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== hdl/u8dec_char_if.sv =====
interface u8dec_char_if;
    import u8dec_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CODE_POINT_W-1:0] code_point;
    logic                    bad_sequence;
    logic [SEQ_LEN_W-1:0]    seq_length;

    modport source (output valid, output code_point, output bad_sequence,
                    output seq_length, input ready);
    modport sink   (input valid, input code_point, input bad_sequence,
                    input seq_length, output ready);
endinterface

// ===== hdl/utf8_code_point_decoder.sv =====
// utf8_code_point_decoder: turns a byte stream into code points (legacy
// utf-8, sequences of one to six bytes)
// i_byte: sink channel, one raw byte per item
// o_char: source channel, one decoded character per item with code_point,
//   bad_sequence and seq_length; bad leads and malformed sequences give
//   code_point 0 with bad_sequence set
// a byte is taken whenever i_byte.ready is high; the character appears in the cycle after the
//   byte that completes it is accepted (ascii and bad leads: that byte itself)
// throughput: one byte per cycle while i_byte.ready is high; bytes inside a sequence give no item
// the output register holds the result while o_char.ready is low; a new
//   byte is still taken in that cycle if the register frees up at the same
//   edge, otherwise i_byte.ready drops until the result is taken
// reset (i_rst_n low, synchronous) drops any partial sequence and empties
//   the output register
module utf8_code_point_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    u8dec_byte_if.sink          i_byte,
    u8dec_char_if.source        o_char
);
    import u8dec_pkg::*;

    // sequence state
    logic [SEQ_LEN_W-1:0]    r_remaining, n_remaining;
    logic [SEQ_LEN_W-1:0]    r_seq_len,   n_seq_len;
    logic                    r_seq_err,   n_seq_err;
    logic [CODE_POINT_W-1:0] r_acc,       n_acc;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic [CODE_POINT_W-1:0] r_code,      n_code;
    logic                    r_bad,       n_bad;
    logic [SEQ_LEN_W-1:0]    r_len,       n_len;

    logic                    in_acc;
    logic                    emit;
    logic [CODE_POINT_W-1:0] emit_code;
    logic                    emit_bad;
    logic [SEQ_LEN_W-1:0]    emit_len;
    logic [SEQ_LEN_W-1:0]    lead_len;
    logic [SEQ_LEN_W-1:0]    rem_dec;
    logic                    cont_bad;
    logic [CODE_POINT_W-1:0] acc_shift;

    // take a byte while the output register is empty or being drained
    assign i_byte.ready = !r_out_valid || o_char.ready;
    assign in_acc       = i_byte.valid && i_byte.ready;

    assign lead_len  = lead_length(i_byte.byte_in);
    assign rem_dec   = r_remaining - 3'd1;
    assign cont_bad  = i_byte.byte_in[7:6] != CONT_TAG;
    assign acc_shift = {r_acc[CODE_POINT_W-PAYLOAD_W-1:0], i_byte.byte_in[PAYLOAD_W-1:0]};

    always_comb begin
        n_remaining = r_remaining;
        n_seq_len   = r_seq_len;
        n_seq_err   = r_seq_err;
        n_acc       = r_acc;
        emit        = 1'b0;
        emit_code   = '0;
        emit_bad    = 1'b0;
        emit_len    = LEN_ONE;
        if (in_acc) begin
            if (r_remaining != '0) begin
                // continuation byte: consumed even when malformed
                n_remaining = rem_dec;
                n_seq_err   = r_seq_err | cont_bad;
                n_acc       = acc_shift;
                if (rem_dec == '0) begin
                    emit      = 1'b1;
                    emit_code = n_seq_err ? '0 : acc_shift;
                    emit_bad  = n_seq_err;
                    emit_len  = r_seq_len;
                    n_acc     = '0;
                    n_seq_err = 1'b0;
                    n_seq_len = '0;
                end
            end else if (lead_len == LEN_ONE) begin
                emit      = 1'b1;
                emit_code = CODE_POINT_W'(i_byte.byte_in);
            end else if (lead_len == LEN_INVALID) begin
                emit      = 1'b1;
                emit_bad  = 1'b1;
            end else begin
                // lead of a multi-byte sequence
                n_acc       = CODE_POINT_W'(lead_payload(i_byte.byte_in, lead_len));
                n_seq_err   = 1'b0;
                n_seq_len   = lead_len;
                n_remaining = lead_len - 3'd1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_code      = r_code;
        n_bad       = r_bad;
        n_len       = r_len;
        if (emit) begin
            n_out_valid = 1'b1;
            n_code      = emit_code;
            n_bad       = emit_bad;
            n_len       = emit_len;
        end else if (o_char.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_seq_len   <= '0;
            r_seq_err   <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_seq_len   <= n_seq_len;
            r_seq_err   <= n_seq_err;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_bad  <= n_bad;
        r_len  <= n_len;
    end

    assign o_char.valid        = r_out_valid;
    assign o_char.code_point   = r_code;
    assign o_char.bad_sequence = r_bad;
    assign o_char.seq_length   = r_len;

endmodule

// ===== hdl/u8dec_checker.sv =====
`include "utf8_code_point_decoder_defines.svh"

module u8dec_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [u8dec_pkg::CODE_POINT_W-1:0] i_code_point,
    input logic                              i_bad_sequence,
    input logic [u8dec_pkg::SEQ_LEN_W-1:0]    i_seq_length
);
    import u8dec_pkg::*;

    // output register is empty right after reset
    `U8D_ASSERT_ALWAYS(a_empty_after_reset, !$past(i_rst_n) |-> !i_out_valid, "item after reset")

    // a stalled item holds
    `U8D_ASSERT(a_stall_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_point) && $stable(i_bad_sequence) && $stable(i_seq_length), "stalled item changed")

    // a bad sequence carries code 0
    `U8D_ASSERT(a_bad_zero, i_out_valid && i_bad_sequence |-> i_code_point == '0, "bad item with nonzero code")

    // single-byte good characters are ascii
    `U8D_ASSERT(a_ascii, i_out_valid && !i_bad_sequence && i_seq_length == LEN_ONE |-> i_code_point < CODE_POINT_W'(128), "single byte above ascii")

    // length stays within one to six
    `U8D_ASSERT(a_len_range, i_out_valid |-> i_seq_length != LEN_INVALID && i_seq_length != 3'd7, "length out of range")

endmodule

bind utf8_code_point_decoder u8dec_checker u_u8dec_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_char.valid),
    .i_out_ready    (o_char.ready),
    .i_code_point   (o_char.code_point),
    .i_bad_sequence (o_char.bad_sequence),
    .i_seq_length   (o_char.seq_length)
);

// ===== tb/utf8_code_point_decoder_tb.sv =====
module utf8_code_point_decoder_tb;
    import u8dec_pkg::*;

    localparam int RUN_LIMIT   = 200000;  // cycles, far above the slowest legal run
    localparam int RANDOM_BYTES = 500;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              drain;  // hold this byte until no character is outstanding
        logic              calm;   // no idling on either side for this item
    } t_byte_item;

    typedef struct {
        logic [CODE_POINT_W-1:0] code_point;
        logic                    bad_sequence;
        logic [SEQ_LEN_W-1:0]    seq_length;
    } t_char_item;

    logic i_clk;
    logic i_rst_n;

    u8dec_byte_if byte_bus ();
    u8dec_char_if char_bus ();

    utf8_code_point_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_char  (char_bus)
    );

    // clock: period 10
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_byte_item pending_bytes[$];
    t_char_item expected_chars[$];

    // decoder shadow state
    logic [SEQ_LEN_W-1:0]    cont_left;
    logic [CODE_POINT_W-1:0] partial_cp;
    logic                    cont_broken;
    logic [SEQ_LEN_W-1:0]    announced_len;

    logic byte_taken;
    logic char_taken;
    logic in_flight;
    logic calm_now;
    int   send_gap;
    int   take_gap;
    int   mismatches;
    int   cycle_count;
    t_byte_item head;

    // length announced by a lead byte: count of leading ones, LEN_INVALID for
    // a stray continuation byte or 0xfe/0xff
    function automatic logic [SEQ_LEN_W-1:0] announced_length(input logic [BYTE_W-1:0] b);
        if (!b[7]) return LEN_ONE;
        if (!b[6]) return LEN_INVALID;
        if (!b[5]) return 3'd2;
        if (!b[4]) return 3'd3;
        if (!b[3]) return 3'd4;
        if (!b[2]) return 3'd5;
        if (!b[1]) return 3'd6;
        return LEN_INVALID;
    endfunction

    // advance the shadow decoder by one byte; has_char tells whether a
    // character completes on this byte
    task automatic decode_byte(input logic [BYTE_W-1:0] b, output logic has_char,
                               output t_char_item ch);
        logic [SEQ_LEN_W-1:0] len;
        logic [7:0]           keep_mask;
        has_char = 1'b0;
        ch = '{default: '0};
        if (cont_left != 0) begin
            // inside a sequence: any byte is consumed, malformed ones poison it
            if (b[7:6] != CONT_TAG)
                cont_broken = 1'b1;
            partial_cp = {partial_cp[CODE_POINT_W-PAYLOAD_W-1:0], b[PAYLOAD_W-1:0]};
            cont_left  = cont_left - 3'd1;
            if (cont_left == 0) begin
                has_char        = 1'b1;
                ch.code_point   = cont_broken ? '0 : partial_cp;
                ch.bad_sequence = cont_broken;
                ch.seq_length   = announced_len;
                partial_cp      = '0;
                cont_broken     = 1'b0;
                announced_len   = '0;
            end
        end else begin
            len = announced_length(b);
            if (len == LEN_ONE) begin
                has_char        = 1'b1;
                ch.code_point   = {{(CODE_POINT_W-BYTE_W){1'b0}}, b};
                ch.bad_sequence = 1'b0;
                ch.seq_length   = LEN_ONE;
            end else if (len == LEN_INVALID) begin
                has_char        = 1'b1;
                ch.code_point   = '0;
                ch.bad_sequence = 1'b1;
                ch.seq_length   = LEN_ONE;
            end else begin
                keep_mask     = 8'hFF >> (len + 3'd1);
                partial_cp    = {{(CODE_POINT_W-BYTE_W){1'b0}}, b & keep_mask};
                cont_broken   = 1'b0;
                announced_len = len;
                cont_left     = len - 3'd1;
            end
        end
    endtask

    task automatic report_field(input string field, input logic [CODE_POINT_W-1:0] want,
                                input logic [CODE_POINT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        end
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic drain,
                              input logic calm);
        t_byte_item it;
        it.value = b;
        it.drain = drain;
        it.calm  = calm;
        pending_bytes = {pending_bytes, it};
    endtask

    // monitor: handshakes seen at the rising edge feed the shadow decoder and
    // the comparison
    always @(posedge i_clk) begin
        logic       has_char;
        t_char_item predicted;
        t_char_item want;
        if (!i_rst_n) begin
            byte_taken    <= 1'b0;
            char_taken    <= 1'b0;
            cont_left     = '0;
            partial_cp    = '0;
            cont_broken   = 1'b0;
            announced_len = '0;
        end else begin
            byte_taken <= byte_bus.valid && byte_bus.ready;
            char_taken <= char_bus.valid && char_bus.ready;
            if (byte_bus.valid && byte_bus.ready) begin
                decode_byte(byte_bus.byte_in, has_char, predicted);
                if (has_char)
                    expected_chars = {expected_chars, predicted};
            end
            if (char_bus.valid && char_bus.ready) begin
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected character, expected none actual %h/%b/%0d",
                             $time, char_bus.code_point, char_bus.bad_sequence,
                             char_bus.seq_length);
                end else begin
                    want = expected_chars.pop_front();
                    report_field("code_point", want.code_point, char_bus.code_point);
                    report_field("bad_sequence", CODE_POINT_W'(want.bad_sequence),
                                 CODE_POINT_W'(char_bus.bad_sequence));
                    report_field("seq_length", CODE_POINT_W'(want.seq_length),
                                 CODE_POINT_W'(char_bus.seq_length));
                end
            end
        end
    end

    // byte driver: one item at a time from the pending queue, random gap
    // after each non-calm item, optional drain hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_bus.valid   <= 1'b0;
            byte_bus.byte_in <= '0;
            in_flight = 1'b0;
            send_gap  = 0;
            calm_now  = 1'b0;
        end else begin
            if (byte_taken)
                in_flight = 1'b0;
            if (!in_flight) begin
                if (send_gap > 0) begin
                    send_gap--;
                    byte_bus.valid   <= 1'b0;
                    byte_bus.byte_in <= BYTE_W'($urandom);
                end else if (pending_bytes.size() > 0 &&
                             !(pending_bytes[0].drain && expected_chars.size() != 0)) begin
                    head = pending_bytes.pop_front();
                    byte_bus.valid   <= 1'b1;
                    byte_bus.byte_in <= head.value;
                    in_flight = 1'b1;
                    calm_now  = head.calm;
                    send_gap  = head.calm ? 0 : $urandom_range(0, 10);
                end else begin
                    byte_bus.valid   <= 1'b0;
                    byte_bus.byte_in <= BYTE_W'($urandom);
                end
            end
        end
    end

    // character sink: random stall after each accepted item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            char_bus.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (char_taken)
                take_gap = calm_now ? 0 : $urandom_range(0, 10);
            if (take_gap > 0) begin
                take_gap--;
                char_bus.ready <= 1'b0;
            end else begin
                char_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int                   sent;
        int                   len;
        int                   phase;
        logic                 calm;
        logic                 drain;
        logic [BYTE_W-1:0]    b;

        mismatches  = 0;
        cycle_count = 0;
        byte_bus.valid   = 1'b0;
        byte_bus.byte_in = '0;
        char_bus.ready   = 1'b0;
        i_rst_n          = 1'b0;

        // directed: ascii extremes, stray and out-of-range leads
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h7F, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'hFE, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        // smallest two-byte, largest two- and three-byte
        queue_byte(8'hC0, 1'b0, 1'b0); queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'hDF, 1'b0, 1'b0); queue_byte(8'hBF, 1'b0, 1'b0);
        queue_byte(8'hEF, 1'b0, 1'b0); queue_byte(8'hBF, 1'b0, 1'b0);
        queue_byte(8'hBF, 1'b0, 1'b0);
        // four- and five-byte forms
        queue_byte(8'hF0, 1'b0, 1'b0);
        repeat (3) queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'hFB, 1'b0, 1'b0);
        repeat (4) queue_byte(8'hBF, 1'b0, 1'b0);
        // largest six-byte value fills all 31 bits
        queue_byte(8'hFD, 1'b0, 1'b0);
        repeat (5) queue_byte(8'hBF, 1'b0, 1'b0);
        // malformed continuation: ascii and a lead byte are swallowed; the
        // opening lead 0xE1 waits until every earlier character has been taken
        queue_byte(8'hE1, 1'b1, 1'b0); queue_byte(8'h41, 1'b0, 1'b0);
        queue_byte(8'hC3, 1'b0, 1'b0);

        // random: mostly well-formed sequences, some noise and broken ones
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            phase = sent / 60;
            calm  = (phase % 4) == 3;  // a stretch with no idling
            drain = (sent % 100) < 6 && phase != 0 && $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 99) < 10) begin
                queue_byte(BYTE_W'($urandom), drain, calm);
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                if (len == 1)
                    b = BYTE_W'($urandom) & 8'h7F;
                else
                    b = BYTE_W'(8'hFF << (8 - len)) | (BYTE_W'($urandom) & (8'hFF >> (len + 1)));
                queue_byte(b, drain, calm);
                sent++;
                for (int k = 1; k < len; k++) begin
                    if ($urandom_range(0, 99) < 8)
                        b = BYTE_W'($urandom);  // likely breaks the sequence
                    else
                        b = {CONT_TAG, PAYLOAD_W'($urandom)};
                    queue_byte(b, 1'b0, calm);
                    sent++;
                end
            end
        end

        // synchronous reset, released on a falling clock edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_bytes.size() != 0 || in_flight)
            @(posedge i_clk);
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_chars.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/u8dec_pkg.sv
hdl/u8dec_byte_if.sv
hdl/u8dec_char_if.sv
hdl/utf8_code_point_decoder.sv
hdl/u8dec_checker.sv
tb/utf8_code_point_decoder_tb.sv
